### src/bcle_pkg.sv
// Shared types, constants and helper function of the block-cyclic local extent block.
package bcle_pkg;

  localparam int GRID_W     = 13;
  localparam int MAT_W      = 20;
  localparam int BLK_W      = 16;
  localparam int COORD_W    = 13;
  localparam int OUT_W      = 21;
  localparam int DVD_W      = COORD_W - 1;
  localparam int MOD_STEPS  = 3;
  localparam int MOD_STAGES = DVD_W / MOD_STEPS;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  typedef struct packed {
    logic [GRID_W-1:0] grid_rows;
    logic [GRID_W-1:0] grid_cols;
    logic [MAT_W-1:0]  matrix_rows;
    logic [MAT_W-1:0]  matrix_cols;
    logic [BLK_W-1:0]  block_rows;
    logic [BLK_W-1:0]  block_cols;
  } cfg_regs_t;

  // per-dimension constants derived from the config registers
  typedef struct packed {
    logic [GRID_W-1:0] p;
    logic [BLK_W-1:0]  b;
    logic [MAT_W-1:0]  base;
    logic [GRID_W-1:0] extra;
    logic [BLK_W-1:0]  rem;
  } dim_cfg_t;

  typedef struct packed {
    logic [DVD_W-1:0] part;
    logic [DVD_W-1:0] dvd;
  } mod_lane_t;

  typedef struct packed {
    mod_lane_t row;
    mod_lane_t col;
    logic      neg;
  } mod_word_t;

  // one restoring step of coord mod p
  function automatic mod_lane_t mod_step(mod_lane_t x, logic [GRID_W-1:0] p);
    logic [DVD_W:0] sh;
    logic [DVD_W:0] diff;
    mod_lane_t      y;
    sh    = {x.part, x.dvd[DVD_W-1]};
    diff  = sh - (DVD_W+1)'(p);
    y.dvd = {x.dvd[DVD_W-2:0], 1'b0};
    if (sh >= (DVD_W+1)'(p)) begin
      y.part = diff[DVD_W-1:0];
    end else begin
      y.part = sh[DVD_W-1:0];
    end
    return y;
  endfunction

endpackage

### src/bcle_cfg.sv
// APB register file holding grid, matrix and block sizes.
module bcle_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcle_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcle_pkg::DATA_W-1:0]  pwdata,
  output logic [bcle_pkg::DATA_W-1:0]  prdata,
  output bcle_pkg::cfg_regs_t          regs,
  output logic                         wr
);

  localparam logic [2:0] REG_GRID_ROWS   = 3'd0;
  localparam logic [2:0] REG_GRID_COLS   = 3'd1;
  localparam logic [2:0] REG_MATRIX_ROWS = 3'd2;
  localparam logic [2:0] REG_MATRIX_COLS = 3'd3;
  localparam logic [2:0] REG_BLOCK_ROWS  = 3'd4;
  localparam logic [2:0] REG_BLOCK_COLS  = 3'd5;

  logic [2:0] idx;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.grid_rows   <= bcle_pkg::GRID_W'(1);
      regs.grid_cols   <= bcle_pkg::GRID_W'(1);
      regs.matrix_rows <= '0;
      regs.matrix_cols <= '0;
      regs.block_rows  <= bcle_pkg::BLK_W'(1);
      regs.block_cols  <= bcle_pkg::BLK_W'(1);
    end else if (wr) begin
      unique case (idx)
        REG_GRID_ROWS:   regs.grid_rows   <= pwdata[bcle_pkg::GRID_W-1:0];
        REG_GRID_COLS:   regs.grid_cols   <= pwdata[bcle_pkg::GRID_W-1:0];
        REG_MATRIX_ROWS: regs.matrix_rows <= pwdata[bcle_pkg::MAT_W-1:0];
        REG_MATRIX_COLS: regs.matrix_cols <= pwdata[bcle_pkg::MAT_W-1:0];
        REG_BLOCK_ROWS:  regs.block_rows  <= pwdata[bcle_pkg::BLK_W-1:0];
        REG_BLOCK_COLS:  regs.block_cols  <= pwdata[bcle_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_ROWS:   prdata = bcle_pkg::DATA_W'(regs.grid_rows);
      REG_GRID_COLS:   prdata = bcle_pkg::DATA_W'(regs.grid_cols);
      REG_MATRIX_ROWS: prdata = bcle_pkg::DATA_W'(regs.matrix_rows);
      REG_MATRIX_COLS: prdata = bcle_pkg::DATA_W'(regs.matrix_cols);
      REG_BLOCK_ROWS:  prdata = bcle_pkg::DATA_W'(regs.block_rows);
      REG_BLOCK_COLS:  prdata = bcle_pkg::DATA_W'(regs.block_cols);
      default:         prdata = '0;
    endcase
  end

endmodule

### src/bcle_prep.sv
// Sequencer that derives per-dimension block counts with a shared serial divider.
module bcle_prep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  bcle_pkg::cfg_regs_t  regs,
  output bcle_pkg::dim_cfg_t   rows_cfg,
  output bcle_pkg::dim_cfg_t   cols_cfg,
  output logic                 busy
);

  localparam int MAT_W = bcle_pkg::MAT_W;
  localparam int BLK_W = bcle_pkg::BLK_W;
  localparam int GRID_W = bcle_pkg::GRID_W;
  localparam int CNT_W = $clog2(MAT_W);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_DIV_NB, S_DIV_BP, S_MUL} state_t;

  state_t             state;
  logic               dim;
  logic [CNT_W-1:0]   cnt;
  logic [MAT_W-1:0]   quo;
  logic [BLK_W-1:0]   rmd;
  logic [MAT_W-1:0]   base  [2];
  logic [GRID_W-1:0]  extra [2];
  logic [BLK_W-1:0]   rem   [2];

  logic [GRID_W-1:0]  p_eff [2];
  logic [BLK_W-1:0]   b_eff [2];
  logic [MAT_W-1:0]   n_sel;
  logic [BLK_W-1:0]   div;
  logic [BLK_W:0]     sh;
  logic [BLK_W:0]     diff;
  logic               ge;
  logic [BLK_W-1:0]   rmd_next;
  logic [MAT_W-1:0]   quo_next;
  logic [MAT_W+BLK_W-1:0] prod;
  logic               last;

  always_comb begin
    p_eff[0] = (regs.grid_rows == '0) ? GRID_W'(1) : regs.grid_rows;
    p_eff[1] = (regs.grid_cols == '0) ? GRID_W'(1) : regs.grid_cols;
    b_eff[0] = (regs.block_rows == '0) ? BLK_W'(1) : regs.block_rows;
    b_eff[1] = (regs.block_cols == '0) ? BLK_W'(1) : regs.block_cols;
    n_sel    = dim ? regs.matrix_cols : regs.matrix_rows;
    div      = (state == S_DIV_BP) ? BLK_W'(p_eff[dim]) : b_eff[dim];
    sh       = {rmd, quo[MAT_W-1]};
    diff     = sh - {1'b0, div};
    ge       = (sh >= {1'b0, div});
    rmd_next = ge ? diff[BLK_W-1:0] : sh[BLK_W-1:0];
    quo_next = {quo[MAT_W-2:0], ge};
    prod     = quo * b_eff[dim];
    last     = (cnt == CNT_W'(MAT_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      dim      <= 1'b0;
      cnt      <= '0;
      base[0]  <= '0;
      base[1]  <= '0;
      extra[0] <= '0;
      extra[1] <= '0;
      rem[0]   <= '0;
      rem[1]   <= '0;
    end else if (wr) begin
      state <= S_LOAD;
      dim   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: ;
        S_LOAD: begin
          quo   <= n_sel;
          rmd   <= '0;
          cnt   <= '0;
          state <= S_DIV_NB;
        end
        S_DIV_NB: begin
          quo <= quo_next;
          if (last) begin
            rem[dim] <= rmd_next;
            rmd      <= '0;
            cnt      <= '0;
            state    <= S_DIV_BP;
          end else begin
            rmd <= rmd_next;
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV_BP: begin
          quo <= quo_next;
          rmd <= rmd_next;
          cnt <= cnt + 1'b1;
          if (last) begin
            extra[dim] <= rmd_next[GRID_W-1:0];
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          base[dim] <= prod[MAT_W-1:0];
          if (!dim) begin
            dim   <= 1'b1;
            state <= S_LOAD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  assign rows_cfg = '{p: p_eff[0], b: b_eff[0], base: base[0], extra: extra[0], rem: rem[0]};
  assign cols_cfg = '{p: p_eff[1], b: b_eff[1], base: base[1], extra: extra[1], rem: rem[1]};

endmodule

### src/bcle_modstage.sv
// One pipeline stage of the coordinate modulo, MOD_STEPS restoring steps per lane.
module bcle_modstage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bcle_pkg::mod_word_t          in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bcle_pkg::mod_word_t          out_word,
  input  logic [bcle_pkg::GRID_W-1:0]  p_rows,
  input  logic [bcle_pkg::GRID_W-1:0]  p_cols
);

  logic                valid;
  bcle_pkg::mod_word_t word;
  bcle_pkg::mod_word_t word_next;

  always_comb begin
    word_next = in_word;
    for (int i = 0; i < bcle_pkg::MOD_STEPS; i++) begin
      word_next.row = bcle_pkg::mod_step(word_next.row, p_rows);
      word_next.col = bcle_pkg::mod_step(word_next.col, p_cols);
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

### src/bcle_pipe.sv
// Item pipeline: modulo stages followed by the count select and output register.
module bcle_pipe (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bcle_pkg::COORD_W-1:0] row_coord,
  input  logic signed [bcle_pkg::COORD_W-1:0] col_coord,
  input  bcle_pkg::dim_cfg_t                  rows_cfg,
  input  bcle_pkg::dim_cfg_t                  cols_cfg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bcle_pkg::OUT_W-1:0]   local_rows,
  output logic signed [bcle_pkg::OUT_W-1:0]   local_cols
);

  localparam int N = bcle_pkg::MOD_STAGES;
  localparam int OUT_W = bcle_pkg::OUT_W;
  localparam int DVD_W = bcle_pkg::DVD_W;

  logic                 v     [N+1];
  logic                 rdy   [N+1];
  bcle_pkg::mod_word_t  w     [N+1];

  logic                 valid;
  logic                 last_ready;
  logic [OUT_W-1:0]     rows_next;
  logic [OUT_W-1:0]     cols_next;

  function automatic logic [OUT_W-1:0] pick(logic [DVD_W-1:0] d, bcle_pkg::dim_cfg_t c);
    logic [bcle_pkg::BLK_W-1:0] add;
    if (bcle_pkg::GRID_W'(d) < c.extra) begin
      add = c.b;
    end else if (bcle_pkg::GRID_W'(d) == c.extra) begin
      add = c.rem;
    end else begin
      add = '0;
    end
    return OUT_W'(c.base) + OUT_W'(add);
  endfunction

  assign v[0]     = in_valid;
  assign in_ready = rdy[0];
  assign w[0].row = '{part: '0, dvd: row_coord[DVD_W-1:0]};
  assign w[0].col = '{part: '0, dvd: col_coord[DVD_W-1:0]};
  assign w[0].neg = row_coord[bcle_pkg::COORD_W-1] | col_coord[bcle_pkg::COORD_W-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    bcle_modstage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[k]),
      .in_ready  (rdy[k]),
      .in_word   (w[k]),
      .out_valid (v[k+1]),
      .out_ready (rdy[k+1]),
      .out_word  (w[k+1]),
      .p_rows    (rows_cfg.p),
      .p_cols    (cols_cfg.p)
    );
  end

  assign last_ready = !valid || out_ready;
  assign rdy[N]     = last_ready;

  always_comb begin
    rows_next = w[N].neg ? '1 : pick(w[N].row.part, rows_cfg);
    cols_next = w[N].neg ? '1 : pick(w[N].col.part, cols_cfg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (last_ready) begin
      valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && v[N]) begin
      local_rows <= rows_next;
      local_cols <= cols_next;
    end
  end

  assign out_valid = valid;

endmodule

### src/block_cyclic_local_extent_top.sv
// Top level of the block-cyclic local extent block.
//
// Input channel (in_valid/in_ready) takes one word of process coordinates,
// row_coord and col_coord. Output channel (out_valid/out_ready) returns one
// word with local_rows and local_cols, the rows and columns that process owns;
// both read -1 if either coordinate is negative.
// Grid, matrix and block sizes sit in APB registers at byte address 4*i.
// A word accepted on in_ready passes through four modulo stages of three
// restoring steps each, the first loaded at the accepting edge, and then
// through the output register before it shows on out_valid.
// Throughput: one word per cycle while out_ready is high and no config pass runs.
// Each config write starts a pass of the serial divider that
// derives block counts for rows, then columns; in_ready is low during it.
// Reset clears all valid bits and loads the register defaults with their
// derived counts, so no pass runs after reset.
// A stalled receiver holds the output word; each stage keeps its word and
// the pipeline fills up before in_ready drops.
module block_cyclic_local_extent_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bcle_pkg::ADDR_W-1:0]         paddr,
  input  logic [bcle_pkg::DATA_W-1:0]         pwdata,
  output logic [bcle_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bcle_pkg::COORD_W-1:0] row_coord,
  input  logic signed [bcle_pkg::COORD_W-1:0] col_coord,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bcle_pkg::OUT_W-1:0]   local_rows,
  output logic signed [bcle_pkg::OUT_W-1:0]   local_cols
);

  bcle_pkg::cfg_regs_t regs;
  bcle_pkg::dim_cfg_t  rows_cfg;
  bcle_pkg::dim_cfg_t  cols_cfg;
  logic                cfg_wr;
  logic                busy;
  logic                pipe_ready;
  logic                gate;

  assign pready   = 1'b1;
  assign gate     = !busy && !cfg_wr;
  assign in_ready = pipe_ready && gate;

  bcle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .regs    (regs),
    .wr      (cfg_wr)
  );

  bcle_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .wr       (cfg_wr),
    .regs     (regs),
    .rows_cfg (rows_cfg),
    .cols_cfg (cols_cfg),
    .busy     (busy)
  );

  bcle_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid && gate),
    .in_ready   (pipe_ready),
    .row_coord  (row_coord),
    .col_coord  (col_coord),
    .rows_cfg   (rows_cfg),
    .cols_cfg   (cols_cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .local_rows (local_rows),
    .local_cols (local_cols)
  );

  a_wr_starts_pass: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("config write did not start the derive pass");

  a_extra_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (rows_cfg.extra < rows_cfg.p) && (cols_cfg.extra < cols_cfg.p))
    else $error("derived extra block count out of range");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (rows_cfg.rem < rows_cfg.b) && (cols_cfg.rem < cols_cfg.b))
    else $error("derived partial block size out of range");

  a_neg_both: assert property (@(posedge clk) disable iff (rst)
    (out_valid && local_rows[bcle_pkg::OUT_W-1]) |-> (local_cols == '1))
    else $error("negative marker on one count only");

endmodule

### dv/block_cyclic_local_extent_top_tb.sv
// Testbench for block_cyclic_local_extent_top: directed and random words vs. a count predictor.
module block_cyclic_local_extent_top_tb;
  import bcle_pkg::*;

  typedef enum int {
    REG_GRID_ROWS,
    REG_GRID_COLS,
    REG_MATRIX_ROWS,
    REG_MATRIX_COLS,
    REG_BLOCK_ROWS,
    REG_BLOCK_COLS,
    REG_SPARE
  } reg_idx_t;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 56;

  class extent_scoreboard;
    logic [GRID_W-1:0] grid_r, grid_c;
    logic [MAT_W-1:0]  mat_r, mat_c;
    logic [BLK_W-1:0]  blk_r, blk_c;
    logic [OUT_W-1:0]  exp_rows[$];
    logic [OUT_W-1:0]  exp_cols[$];
    int unsigned       errors, checked, accepted, invalid;

    function new();
      grid_r = 1;
      grid_c = 1;
      mat_r  = 0;
      mat_c  = 0;
      blk_r  = 1;
      blk_c  = 1;
    endfunction

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_GRID_ROWS:   grid_r = v[GRID_W-1:0];
        REG_GRID_COLS:   grid_c = v[GRID_W-1:0];
        REG_MATRIX_ROWS: mat_r  = v[MAT_W-1:0];
        REG_MATRIX_COLS: mat_c  = v[MAT_W-1:0];
        REG_BLOCK_ROWS:  blk_r  = v[BLK_W-1:0];
        REG_BLOCK_COLS:  blk_c  = v[BLK_W-1:0];
        default: ;
      endcase
    endfunction

    // rows or columns owned along one grid dimension
    function logic [OUT_W-1:0] owned(logic [COORD_W-1:0] coord, logic [GRID_W-1:0] grid,
                                     logic [MAT_W-1:0] n, logic [BLK_W-1:0] blk);
      int unsigned p, b, d, blocks, count, extra;
      p      = (grid == 0) ? 1 : grid;
      b      = (blk == 0) ? 1 : blk;
      d      = coord % p;
      blocks = n / b;
      count  = (blocks / p) * b;
      extra  = blocks % p;
      if (d < extra) count += b;
      else if (d == extra) count += n % b;
      return OUT_W'(count);
    endfunction

    function void note_input(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      accepted++;
      if (r[COORD_W-1] || c[COORD_W-1]) begin
        invalid++;
        exp_rows.push_back('1);
        exp_cols.push_back('1);
      end else begin
        exp_rows.push_back(owned(r, grid_r, mat_r, blk_r));
        exp_cols.push_back(owned(c, grid_c, mat_c, blk_c));
      end
    endfunction

    function void check(logic [OUT_W-1:0] rows, logic [OUT_W-1:0] cols);
      logic [OUT_W-1:0] er, ec;
      if (exp_rows.size() == 0) begin
        errors++;
        $error("unexpected result word: local_rows %0d local_cols %0d",
               $signed(rows), $signed(cols));
        return;
      end
      er = exp_rows.pop_front();
      ec = exp_cols.pop_front();
      checked++;
      if (rows !== er) begin
        errors++;
        $error("local_rows: expected %0d, got %0d", $signed(er), $signed(rows));
      end
      if (cols !== ec) begin
        errors++;
        $error("local_cols: expected %0d, got %0d", $signed(ec), $signed(cols));
      end
    endfunction

    function int pending();
      return exp_rows.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] row_coord = '0;
  logic signed [COORD_W-1:0] col_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] local_rows;
  logic signed [OUT_W-1:0] local_cols;

  extent_scoreboard extents = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int quiet = 0;
  int settings = 1;

  block_cyclic_local_extent_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .row_coord (row_coord),
    .col_coord (col_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .local_rows(local_rows),
    .local_cols(local_cols)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) extents.check(local_rows, local_cols);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("block_cyclic_local_extent_top_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    extents.write_reg(idx, v);
    // let the block-count pass start, then wait for it to finish
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_config(int gr, int gc, int mr, int mc, int br, int bc);
    reg_write(REG_GRID_ROWS, gr);
    reg_write(REG_GRID_COLS, gc);
    reg_write(REG_MATRIX_ROWS, mr);
    reg_write(REG_MATRIX_COLS, mc);
    reg_write(REG_BLOCK_ROWS, br);
    reg_write(REG_BLOCK_COLS, bc);
    settings++;
  endtask

  task automatic send_word(int r, int c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    row_coord <= COORD_W'(r);
    col_coord <= COORD_W'(c);
    do @(posedge clk); while (!in_ready);
    extents.note_input(COORD_W'(r), COORD_W'(c));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (extents.pending() != 0) @(posedge clk);
  endtask

  // upper pwdata bits beyond the register width are junk the block must drop
  function automatic logic [DATA_W-1:0] junk(int v, int w);
    if ($urandom_range(7) == 0) return DATA_W'(v) | (DATA_W'($urandom) << w);
    return DATA_W'(v);
  endfunction

  function automatic int pick_grid();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(8191, 1);
      2: return 4096;
      default: return $urandom_range(12, 1);
    endcase
  endfunction

  function automatic int pick_matrix();
    case ($urandom_range(7))
      0: return 0;
      1: return 1048575;
      2: return $urandom_range(1048575);
      default: return $urandom_range(200);
    endcase
  endfunction

  function automatic int pick_block();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(65535, 1);
      default: return $urandom_range(9, 1);
    endcase
  endfunction

  function automatic int pick_coord(logic [GRID_W-1:0] grid);
    int g;
    g = (grid == 0) ? 1 : grid;
    case ($urandom_range(9))
      0: return 'h1000 | $urandom_range(4095);
      1, 2: return $urandom_range(4095);
      default: return $urandom_range((2 * g + 1 > 4095) ? 4095 : 2 * g + 1);
    endcase
  endfunction

  task automatic load_random_config();
    reg_write(REG_GRID_ROWS, junk(pick_grid(), GRID_W));
    reg_write(REG_GRID_COLS, junk(pick_grid(), GRID_W));
    reg_write(REG_MATRIX_ROWS, junk(pick_matrix(), MAT_W));
    reg_write(REG_MATRIX_COLS, junk(pick_matrix(), MAT_W));
    reg_write(REG_BLOCK_ROWS, junk(pick_block(), BLK_W));
    reg_write(REG_BLOCK_COLS, junk(pick_block(), BLK_W));
    if ($urandom_range(3) == 0) reg_write(REG_SPARE, $urandom);
    settings++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: empty matrix
    send_word(0, 0);
    send_word(4095, 4095);
    drain();

    // 100 x 47 matrix in 7 x 4 blocks over a 3 x 5 grid, wrap and negatives
    load_config(3, 5, 100, 47, 7, 4);
    send_word(0, 0);
    send_word(1, 1);
    send_word(2, 2);
    send_word(3, 3);
    send_word(4, 4);
    send_word(5, 5);
    send_word(2, 4);
    send_word(4095, 4095);
    send_word(-1, 0);
    send_word(0, -1);
    send_word(-4096, -4096);
    send_word(4095, -1);
    drain();

    load_config(4096, 4096, 1048575, 1048575, 65535, 65535);
    send_word(0, 0);
    send_word(15, 16);
    send_word(4095, 4095);
    drain();

    load_config(1, 1, 1048575, 1048575, 1, 1);
    send_word(0, 4095);
    drain();

    // zero grid and block sizes act as one
    load_config(0, 0, 1048575, 12345, 0, 0);
    send_word(0, 0);
    send_word(7, 3);
    drain();

    reg_write(REG_SPARE, 32'hffff_ffff);
    send_word(1, 2);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_random_config();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 54; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 54; end
        default: begin idle_pct = 38; stall_pct <= 38; end
      endcase
      if (ph == 4) begin
        idle_pct = 0;
        hold_len <= HOLD_CYCLES;
        hold_go  <= ~hold_go;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 2 && k == PHASE_WORDS / 2) begin
          in_valid <= 1'b0;
          while (extents.pending() != 0) @(posedge clk);
        end
        send_word(pick_coord(extents.grid_r), pick_coord(extents.grid_c));
      end
      drain();
    end

    repeat (20) @(posedge clk);

    $display("covered %0d words (%0d with a negative coordinate) over %0d register settings,",
             extents.accepted, extents.invalid, settings);
    $display("%0d result words checked, %0d mismatches", extents.checked, extents.errors);
    if (extents.errors == 0 && extents.pending() == 0) begin
      $display("block_cyclic_local_extent_top_tb: PASS");
    end else begin
      $display("block_cyclic_local_extent_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### block_cyclic_local_extent_top.f
src/bcle_pkg.sv
src/bcle_cfg.sv
src/bcle_prep.sv
src/bcle_modstage.sv
src/bcle_pipe.sv
src/block_cyclic_local_extent_top.sv
dv/block_cyclic_local_extent_top_tb.sv
